/* rtl/ppa_pkg.sv */
// Package: shared codes, constants and types for the proximal pressure alarm.
`timescale 1ns / 1ps
package ppa_pkg;

    localparam int unsigned STATE_W = 3;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned PRESS_W = 12;
    localparam int unsigned PEEP_W  = 10;
    // Compare width: holds pressure, peep + window and peep - window.
    localparam int unsigned CMP_W   = 13;

    localparam logic signed [CMP_W-1:0] WINDOW = 13'sd15;

    // Alarm state codes
    localparam logic [STATE_W-1:0] ST_FALSE     = 3'd0;
    localparam logic [STATE_W-1:0] ST_DETECTED  = 3'd1;
    localparam logic [STATE_W-1:0] ST_TRUE      = 3'd2;
    localparam logic [STATE_W-1:0] ST_DISPLAYED = 3'd3;
    localparam logic [STATE_W-1:0] ST_CANCELED  = 3'd4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_EVAL = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK = 2'd1;
    localparam logic [OP_W-1:0] OP_ACK  = 2'd2;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_RAISED = 2'd1;
    localparam logic [EVENT_W-1:0] EV_END    = 2'd2;

    // Register byte addresses
    localparam int unsigned         ADDR_W         = 3;
    localparam logic [ADDR_W-1:0]   ADDR_ALARM_DLY = 3'd0;

    // One input transaction as held in the input register
    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [PRESS_W-1:0] pressure;
        logic [PEEP_W-1:0]         peep_setting;
        logic                      flat_proxi;
        logic                      inhibit_key;
        logic                      uncancel;
    } t_item;

    // Machine state carried between transactions
    typedef struct packed {
        logic [STATE_W-1:0] alarm_code;
        logic [COUNT_W-1:0] countdown;
        logic               priority_flag;
    } t_fsm_state;

    // Evaluation result: next state plus reported event and error
    typedef struct packed {
        t_fsm_state         next;
        logic [EVENT_W-1:0] event_code;
        logic               state_error;
    } t_eval_res;

endpackage

/* rtl/proximal_pressure_alarm_fsm.sv */
// Top level: proximal pressure alarm machine with input/output registers and APB port.
`timescale 1ns / 1ps
// Path: each transaction passes through the input register, then the result register;
//   the result register holds its result while the output stalls.
// Throughput: one transaction per cycle unless the output stalls; the machine state
//   register is updated once per transaction in evaluation, so back-to-back ones chain.
// Reset: synchronous, active low; clears the alarm state to false, countdown,
//   priority bit, alarm_delay and both stage valid flags.
module proximal_pressure_alarm_fsm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ppa_pkg::OP_W-1:0]      i_op,
    input  logic signed [ppa_pkg::PRESS_W-1:0] i_pressure,
    input  logic [ppa_pkg::PEEP_W-1:0]    i_peep_setting,
    input  logic                          i_flat_proxi,
    input  logic                          i_inhibit_key,
    input  logic                          i_uncancel,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ppa_pkg::STATE_W-1:0]   o_alarm_state,
    output logic                          o_medium_priority,
    output logic [ppa_pkg::EVENT_W-1:0]   o_event_code,
    output logic                          o_state_error,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppa_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ppa_pkg::*;

    // Configuration register
    logic [15:0] r_alarm_delay;
    logic        s_cfg_wr;

    // Input register stage
    logic  r_s1_valid;
    t_item r_s1_item;
    t_item s_in_item;

    // Machine state
    t_fsm_state r_fsm;
    t_eval_res  s_res;

    // Result register stage
    logic               r_out_valid;
    logic [STATE_W-1:0] r_out_state;
    logic               r_out_prio;
    logic [EVENT_W-1:0] r_out_event;
    logic               r_out_err;

    logic s_adv2;
    logic s_acc_in;

    // ---------------------------------------------------------------------
    // APB: always ready; only the word at address zero holds a register.
    // ---------------------------------------------------------------------
    assign pready   = 1'b1;
    assign s_cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_ALARM_DLY[2]);
    assign prdata   = (paddr[2] == ADDR_ALARM_DLY[2]) ? {16'd0, r_alarm_delay} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_delay <= '0;
        end else if (s_cfg_wr) begin
            r_alarm_delay <= pwdata[15:0];
        end
    end

    // ---------------------------------------------------------------------
    // Handshake: advance evaluation when the result register is free or
    // being drained; accept a new transaction when stage one is empty or moves on.
    // ---------------------------------------------------------------------
    assign s_adv2     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s_adv2;
    assign s_acc_in   = i_in_valid && !o_in_stall;

    assign s_in_item.op           = i_op;
    assign s_in_item.pressure     = i_pressure;
    assign s_in_item.peep_setting = i_peep_setting;
    assign s_in_item.flat_proxi   = i_flat_proxi;
    assign s_in_item.inhibit_key  = i_inhibit_key;
    assign s_in_item.uncancel     = i_uncancel;

    // Input register: capture payload on accept, drop valid once consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_acc_in) begin
            r_s1_valid <= 1'b1;
        end else if (s_adv2) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc_in) begin
            r_s1_item <= s_in_item;
        end
    end

    // Evaluation: compares against the PEEP window and the state transition
    ppa_eval u_eval (
        .i_item        (r_s1_item),
        .i_cur         (r_fsm),
        .i_alarm_delay (r_alarm_delay),
        .o_res         (s_res)
    );

    // Machine state advances once per evaluated transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= '{alarm_code: ST_FALSE, countdown: '0, priority_flag: 1'b0};
        end else if (s_adv2) begin
            r_fsm <= s_res.next;
        end
    end

    // Result register: hold while stalled, load on every evaluation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv2) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv2) begin
            r_out_state <= s_res.next.alarm_code;
            r_out_prio  <= s_res.next.priority_flag;
            r_out_event <= s_res.event_code;
            r_out_err   <= s_res.state_error;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_alarm_state     = r_out_state;
    assign o_medium_priority = r_out_prio;
    assign o_event_code      = r_out_event;
    assign o_state_error     = r_out_err;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // A raised event always lands in the true state with the priority bit set
    a_raise_sets_prio : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_code == EV_RAISED)) |->
            (o_alarm_state == ST_TRUE) && o_medium_priority)
        else $error("raised event without true state and priority");

    // An end-of-alarm event always returns the machine to false
    a_end_to_false : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_code == EV_END)) |-> (o_alarm_state == ST_FALSE))
        else $error("end event without false state");

    // Priority bit is set exactly in the true and displayed states
    a_prio_tracks_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm.priority_flag ==
            ((r_fsm.alarm_code == ST_TRUE) || (r_fsm.alarm_code == ST_DISPLAYED)))
        else $error("priority bit out of step with alarm state");

    // A timer tick never raises the countdown
    a_tick_no_rise : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_adv2 && (r_s1_item.op == OP_TICK)) |=>
            (r_fsm.countdown <= $past(r_fsm.countdown)))
        else $error("countdown rose on a timer tick");

endmodule

/* rtl/ppa_eval.sv */
// Next-state and event logic of the proximal pressure alarm machine.
`timescale 1ns / 1ps
module ppa_eval (
    input  ppa_pkg::t_item      i_item,
    input  ppa_pkg::t_fsm_state i_cur,
    input  logic [15:0]         i_alarm_delay,
    output ppa_pkg::t_eval_res  o_res
);
    import ppa_pkg::*;

    logic signed [CMP_W-1:0] s_press;
    logic signed [CMP_W-1:0] s_peep;
    logic signed [CMP_W-1:0] s_hi;
    logic signed [CMP_W-1:0] s_lo;
    logic                    s_err;
    logic                    s_detect;
    logic                    s_clear;

    assign s_press = CMP_W'(i_item.pressure);
    assign s_peep  = signed'({{(CMP_W-PEEP_W){1'b0}}, i_item.peep_setting});
    assign s_hi    = s_peep + WINDOW;
    assign s_lo    = s_peep - WINDOW;
    assign s_err   = !(i_cur.alarm_code inside {ST_FALSE, ST_DETECTED, ST_TRUE,
                                                 ST_DISPLAYED, ST_CANCELED});

    // Window edges and pressure equal to the window neither detect nor clear
    assign s_detect = i_item.flat_proxi && ((s_press > s_hi) || (s_press < s_lo))
                      && (s_press > WINDOW);
    assign s_clear  = !i_item.flat_proxi || ((s_press < s_hi) && (s_press > s_lo))
                      || (s_press < WINDOW);

    always_comb begin
        o_res.next        = i_cur;
        o_res.event_code  = EV_NONE;
        o_res.state_error = s_err;
        case (i_item.op)
            OP_EVAL: begin
                if (!s_err) begin
                    case (i_cur.alarm_code)
                        ST_FALSE: begin
                            if (s_detect) begin
                                o_res.next.alarm_code = ST_DETECTED;
                                o_res.next.countdown  = i_alarm_delay;
                            end
                        end
                        ST_DETECTED: begin
                            if (s_clear) begin
                                o_res.next.alarm_code = ST_FALSE;
                            end else if (i_cur.countdown == '0) begin
                                o_res.next.alarm_code    = ST_TRUE;
                                o_res.next.priority_flag = 1'b1;
                                o_res.event_code         = EV_RAISED;
                            end
                        end
                        ST_DISPLAYED: begin
                            if (s_clear) begin
                                o_res.next.alarm_code    = ST_FALSE;
                                o_res.next.priority_flag = 1'b0;
                                o_res.event_code         = EV_END;
                            end else if (i_item.inhibit_key) begin
                                o_res.next.alarm_code    = ST_CANCELED;
                                o_res.next.priority_flag = 1'b0;
                            end
                        end
                        ST_CANCELED: begin
                            if (s_clear) begin
                                o_res.next.alarm_code = ST_FALSE;
                                o_res.event_code      = EV_END;
                            end else if (i_item.uncancel) begin
                                o_res.next.alarm_code    = ST_TRUE;
                                o_res.next.priority_flag = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_TICK: begin
                // Count down and hold at zero
                if (i_cur.countdown != '0) begin
                    o_res.next.countdown = i_cur.countdown - COUNT_W'(1);
                end
            end
            OP_ACK: begin
                if (i_cur.alarm_code == ST_TRUE) begin
                    o_res.next.alarm_code = ST_DISPLAYED;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* tb/sv/proximal_pressure_alarm_fsm_tb.sv */
// Testbench: proximal pressure alarm machine checked transaction by transaction against a predictor.
`timescale 1ns / 1ps
module proximal_pressure_alarm_fsm_tb;
    import ppa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WIN         = int'(WINDOW);
    localparam int PRESS_MAX   = 2047;
    localparam int PRESS_MIN   = -2048;
    localparam int PEEP_MAX    = 1000;
    localparam int MAX_GAP     = 16;
    localparam int MAX_SHOWN   = 10;
    localparam int CYCLE_LIMIT = 200000;

    // One result transaction as seen on the output channel
    typedef struct packed {
        logic [STATE_W-1:0] alarm_state;
        logic               medium_priority;
        logic [EVENT_W-1:0] event_code;
        logic               state_error;
    } t_alarm_report;

    // Pressure classes relative to the PEEP window
    typedef enum int {PK_DETECT, PK_CLEAR, PK_EDGE, PK_ANY} t_press_kind;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [OP_W-1:0]           i_op;
    logic signed [PRESS_W-1:0] i_pressure;
    logic [PEEP_W-1:0]         i_peep_setting;
    logic                      i_flat_proxi;
    logic                      i_inhibit_key;
    logic                      i_uncancel;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [STATE_W-1:0]        o_alarm_state;
    logic                      o_medium_priority;
    logic [EVENT_W-1:0]        o_event_code;
    logic                      o_state_error;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    proximal_pressure_alarm_fsm i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_pressure        (i_pressure),
        .i_peep_setting    (i_peep_setting),
        .i_flat_proxi      (i_flat_proxi),
        .i_inhibit_key     (i_inhibit_key),
        .i_uncancel        (i_uncancel),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_alarm_state     (o_alarm_state),
        .o_medium_priority (o_medium_priority),
        .o_event_code      (o_event_code),
        .o_state_error     (o_state_error),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Predictor copy of the machine and its register
    logic [COUNT_W-1:0] mdl_delay;
    logic [COUNT_W-1:0] mdl_countdown;
    logic [STATE_W-1:0] mdl_code;
    logic               mdl_prio;

    t_alarm_report reports_due[$];
    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  raises_due;
    int  ends_due;
    int  cycle_count;
    bit  in_burst;
    bit  out_burst;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the machine by one transaction and return the report it must produce.
    function automatic t_alarm_report predict_alarm(t_item it);
        int            p;
        int            peep;
        bit            err;
        bit            detect;
        bit            clear;
        t_alarm_report r;
        p      = int'($signed(it.pressure));
        peep   = int'(it.peep_setting);
        err    = mdl_code > ST_CANCELED;
        detect = it.flat_proxi && (p > peep + WIN || p < peep - WIN) && p > WIN;
        clear  = !it.flat_proxi || (p < peep + WIN && p > peep - WIN) || p < WIN;
        r.event_code = EV_NONE;
        if (it.op == OP_EVAL && !err) begin
            case (mdl_code)
                ST_FALSE: begin
                    if (detect) begin
                        mdl_code      = ST_DETECTED;
                        mdl_countdown = mdl_delay;
                    end
                end
                ST_DETECTED: begin
                    // clear wins over promotion and leaves the priority bit alone
                    if (clear) begin
                        mdl_code = ST_FALSE;
                    end else if (mdl_countdown == '0) begin
                        mdl_code     = ST_TRUE;
                        r.event_code = EV_RAISED;
                        mdl_prio     = 1'b1;
                    end
                end
                ST_DISPLAYED: begin
                    if (clear) begin
                        mdl_code     = ST_FALSE;
                        r.event_code = EV_END;
                        mdl_prio     = 1'b0;
                    end else if (it.inhibit_key) begin
                        mdl_code = ST_CANCELED;
                        mdl_prio = 1'b0;
                    end
                end
                ST_CANCELED: begin
                    if (clear) begin
                        mdl_code     = ST_FALSE;
                        r.event_code = EV_END;
                    end else if (it.uncancel) begin
                        mdl_code = ST_TRUE;
                        mdl_prio = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if (it.op == OP_TICK) begin
            if (mdl_countdown != '0) mdl_countdown = mdl_countdown - 1'b1;
        end else if (it.op == OP_ACK) begin
            if (mdl_code == ST_TRUE) mdl_code = ST_DISPLAYED;
        end
        r.alarm_state     = mdl_code;
        r.medium_priority = mdl_prio;
        r.state_error     = err;
        return r;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function automatic logic signed [PRESS_W-1:0] pick_pressure(int peep, t_press_kind kind);
        int p;
        case (kind)
            PK_DETECT: begin
                // low side exists only when the window sits above the fixed floor
                if (peep >= 2 * WIN + 2 && $urandom_range(0, 2) == 0)
                    p = int'($urandom_range(WIN + 1, peep - WIN - 1));
                else
                    p = int'($urandom_range(peep + WIN + 1, PRESS_MAX));
            end
            PK_CLEAR: begin
                if ($urandom_range(0, 1) == 1)
                    p = peep - WIN + 1 + int'($urandom_range(0, 2 * WIN - 2));
                else
                    p = PRESS_MIN + int'($urandom_range(0, WIN - 1 - PRESS_MIN));
            end
            PK_EDGE: begin
                case ($urandom_range(0, 2))
                    0:       p = peep + WIN;
                    1:       p = peep - WIN;
                    default: p = WIN;
                endcase
            end
            default: p = PRESS_MIN + int'($urandom_range(0, 4095));
        endcase
        return p[PRESS_W-1:0];
    endfunction

    function automatic t_item make_eval(int p, int peep, bit flat, bit inh, bit unc);
        t_item it;
        it.op           = OP_EVAL;
        it.pressure     = p[PRESS_W-1:0];
        it.peep_setting = peep[PEEP_W-1:0];
        it.flat_proxi   = flat;
        it.inhibit_key  = inh;
        it.uncancel     = unc;
        return it;
    endfunction

    // Non-evaluate transaction: the payload fields are don't-care, so randomize them.
    function automatic t_item make_op(logic [OP_W-1:0] op);
        t_item       it;
        logic [31:0] rnd;
        rnd             = $urandom;
        it              = rnd[$bits(t_item)-1:0];
        it.op           = op;
        it.peep_setting = PEEP_W'($urandom_range(0, PEEP_MAX));
        return it;
    endfunction

    // Steer the stimulus through the alarm life cycle from the predicted state;
    // a tenth of the transactions are plain noise.
    function automatic t_item next_stimulus();
        t_item       it;
        int          roll;
        int          peep;
        logic [31:0] rnd;
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       peep = 0;
            1:       peep = PEEP_MAX;
            default: peep = $urandom_range(0, PEEP_MAX);
        endcase
        it = make_eval(0, peep, 1'b1, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        it.pressure = pick_pressure(peep, PK_DETECT);
        if (roll < 10) begin
            rnd = $urandom;
            it  = rnd[$bits(t_item)-1:0];
            if (it.peep_setting > PEEP_MAX) it.peep_setting = PEEP_W'($urandom_range(0, PEEP_MAX));
            return it;
        end
        case (mdl_code)
            ST_FALSE: begin
                if (roll >= 80) it.pressure = pick_pressure(peep, t_press_kind'($urandom_range(1, 3)));
            end
            ST_DETECTED: begin
                if (mdl_countdown != '0 && roll < 65) it = make_op(OP_TICK);
                else if (roll < 75) it.pressure = pick_pressure(peep, PK_EDGE);
                else if (roll >= 88) it.pressure = pick_pressure(peep, PK_CLEAR);
            end
            ST_TRUE: begin
                if (roll < 70) it = make_op(OP_ACK);
                else if (roll < 85) it = make_op(OP_TICK);
                else it.pressure = pick_pressure(peep, PK_ANY);
            end
            ST_DISPLAYED: begin
                if (roll < 45) it.inhibit_key = 1'b1;
                else if (roll < 75) it.pressure = pick_pressure(peep, PK_CLEAR);
                else if (roll < 85) it = make_op(OP_ACK);
                else it.pressure = pick_pressure(peep, PK_ANY);
            end
            ST_CANCELED: begin
                if (roll < 45) it.uncancel = 1'b1;
                else if (roll < 75) it.pressure = pick_pressure(peep, PK_CLEAR);
                else it.pressure = pick_pressure(peep, PK_ANY);
            end
            default: it.pressure = pick_pressure(peep, PK_ANY);
        endcase
        // drop the flat flag now and then; that alone clears an alarm
        if (it.op == OP_EVAL && $urandom_range(0, 9) == 0) it.flat_proxi = 1'b0;
        return it;
    endfunction

    // Present one transaction, hold it until accepted, then record its expected report.
    task automatic send_item(t_item it);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= it.op;
        i_pressure     <= it.pressure;
        i_peep_setting <= it.peep_setting;
        i_flat_proxi   <= it.flat_proxi;
        i_inhibit_key  <= it.inhibit_key;
        i_uncancel     <= it.uncancel;
        do @(posedge i_clk); while (o_in_stall);
        reports_due.push_back(predict_alarm(it));
        items_sent++;
    endtask

    // Wait for every expected report, then let the pipeline settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write alarm_delay over the APB port, then read it back.
    task automatic write_delay(logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ALARM_DLY;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mdl_delay = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(value))
            note_mismatch($sformatf("alarm_delay read exp %0d got %0d", value, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_delay_register();
        write_delay(16'hFFFF);
        write_delay(16'h0000);
    endtask

    // Walk the whole life cycle by hand, including the window edges.
    task automatic test_directed_cycle();
        write_delay(16'd2);
        send_item(make_eval(PRESS_MAX, 0, 1'b1, 1'b0, 1'b0));   // detect high, load countdown
        send_item(make_eval(PRESS_MAX, 0, 1'b1, 1'b0, 1'b0));   // countdown running: hold
        send_item(make_op(OP_TICK));
        send_item(make_op(OP_TICK));
        send_item(make_op(OP_TICK));                            // hold countdown at zero
        send_item(make_eval(500, 0, 1'b1, 1'b0, 1'b0));         // promote: raise event
        send_item(make_eval(500, 0, 1'b1, 1'b1, 1'b1));         // true ignores evaluate
        send_item(make_op(OP_UNUSED));
        send_item(make_op(OP_ACK));                             // true to displayed
        send_item(make_op(OP_ACK));                             // ack elsewhere is ignored
        send_item(make_eval(500, 0, 1'b1, 1'b1, 1'b0));         // inhibit cancels
        send_item(make_eval(500, 0, 1'b1, 1'b0, 1'b1));         // uncancel restores
        send_item(make_op(OP_ACK));
        send_item(make_eval(500, 0, 1'b0, 1'b0, 1'b0));         // flat drops: end event
        send_item(make_eval(115, 100, 1'b1, 1'b0, 1'b0));       // upper edge: no detect
        send_item(make_eval(WIN, 0, 1'b1, 1'b0, 1'b0));         // pressure at floor: no detect
        send_item(make_eval(984, PEEP_MAX, 1'b1, 1'b0, 1'b0));  // detect on the low side
        send_item(make_eval(985, PEEP_MAX, 1'b1, 1'b0, 1'b0));  // lower edge: no clear
        send_item(make_eval(PRESS_MIN, 0, 1'b1, 1'b0, 1'b0));   // below floor: silent clear
        drain_results();
        write_delay(16'd0);
        send_item(make_eval(WIN + 1, 0, 1'b1, 1'b0, 1'b0));
        send_item(make_eval(WIN + 1, 0, 1'b1, 1'b0, 1'b0));     // zero delay promotes at once
        send_item(make_op(OP_ACK));
        send_item(make_eval(WIN + 1, 0, 1'b1, 1'b1, 1'b0));
        send_item(make_eval(PEEP_MAX, PEEP_MAX, 1'b1, 1'b0, 1'b1)); // clear beats uncancel
        drain_results();
    endtask

    // Random life cycles under several delay settings and handshake pressures.
    task automatic test_random_traffic();
        logic [COUNT_W-1:0] delays[6];
        int                 counts[6];
        delays = '{16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0};
        counts = '{80, 80, 40, 80, 40, 80};
        delays[3] = COUNT_W'($urandom_range(2, 12));
        delays[4] = COUNT_W'($urandom);
        delays[5] = COUNT_W'($urandom_range(1, 6));
        for (int ph = 0; ph < 6; ph++) begin
            in_burst  = (ph == 1 || ph == 5);
            out_burst = (ph == 3 || ph == 5);
            write_delay(delays[ph]);
            for (int n = 0; n < counts[ph]; n++) send_item(next_stimulus());
            drain_results();
        end
        in_burst  = 1'b0;
        out_burst = 1'b0;
    endtask

    // Output side: stall a random number of cycles before taking each result, or none in burst phases.
    initial begin : drive_out_stall
        int hold;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = out_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_alarm_report got;
        t_alarm_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_alarm_state, o_medium_priority, o_event_code, o_state_error};
            if (reports_due.size() == 0) begin
                note_mismatch($sformatf("unexpected result state %0d prio %0d event %0d err %0d",
                    got.alarm_state, got.medium_priority, got.event_code, got.state_error));
            end else begin
                want = reports_due.pop_front();
                results_seen++;
                if (want.event_code == EV_RAISED) raises_due++;
                if (want.event_code == EV_END) ends_due++;
                if (got !== want)
                    note_mismatch($sformatf(
                        "result %0d: state exp %0d got %0d, prio exp %0d got %0d, event exp %0d got %0d, err exp %0d got %0d",
                        results_seen, want.alarm_state, got.alarm_state,
                        want.medium_priority, got.medium_priority,
                        want.event_code, got.event_code, want.state_error, got.state_error));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                cycle_count, reports_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : run_tests
        mdl_delay      = '0;
        mdl_countdown  = '0;
        mdl_code       = ST_FALSE;
        mdl_prio       = 1'b0;
        mismatches     = 0;
        results_seen   = 0;
        items_sent     = 0;
        raises_due     = 0;
        ends_due       = 0;
        cycle_count    = 0;
        in_burst       = 1'b0;
        out_burst      = 1'b0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_op           <= OP_EVAL;
        i_pressure     <= '0;
        i_peep_setting <= '0;
        i_flat_proxi   <= 1'b0;
        i_inhibit_key  <= 1'b0;
        i_uncancel     <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_delay_register();
        test_directed_cycle();
        test_random_traffic();

        $display("Sent %0d transactions, checked %0d results (%0d alarm raises, %0d alarm ends)",
            items_sent, results_seen, raises_due, ends_due);
        $display("Delay settings spanned 0 to 65535; %0d mismatches", mismatches);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
